>>> rtl/bsc_pkg.sv
// Shared widths, constants and register codes of the barometric compensation block.
package bsc_pkg;

  localparam int RAW_W      = 20;
  localparam int TEMP_W     = 24;
  localparam int PRESS_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int COEF_W     = 16;

  // Wide pressure datapath and the magnitude of the pressure divisor.
  localparam int WIDE_W  = 64;
  localparam int DEN_W   = 31;
  localparam int MUL_LAT = 2;

  localparam int FINE_OFFSET    = 128000;
  localparam int PRESS_BASE     = 1048576;
  localparam int PRESS_SCALE    = 3125;
  localparam int DIV_BIAS_SHIFT = 47;
  localparam int DIV_SHIFT      = 33;
  localparam int Y_P4_SHIFT     = 35;
  localparam int TEMP_ROUND     = 128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_ONE  = 3'd0,
    REG_TEMP_TWO  = 3'd1,
    REG_TEMP_THREE = 3'd2,
    REG_PRESS_ONE = 3'd3,
    REG_PRESS_2_5 = 3'd4,
    REG_PRESS_6_9 = 3'd5
  } cfg_reg_t;

endpackage

>>> rtl/bsc_channels.sv
// Channel interfaces for raw samples, compensated results and register writes.
interface bsc_sample_if;
  logic                          valid;
  logic                          ready;
  logic [bsc_pkg::RAW_W-1:0]     raw_temperature;
  logic [bsc_pkg::RAW_W-1:0]     raw_pressure;
  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bsc_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [bsc_pkg::TEMP_W-1:0] temperature_centi;
  logic [bsc_pkg::PRESS_W-1:0]      pressure_q24_8;
  logic                             divisor_zero;
  modport source (output valid, output temperature_centi, output pressure_q24_8,
                  output divisor_zero, input ready);
  modport sink (input valid, input temperature_centi, input pressure_q24_8,
                input divisor_zero, output ready);
endinterface

interface bsc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bsc_pkg::CFG_IDX_W-1:0]    index;
  logic [bsc_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/bsc_mul64.sv
// Two-stage 64 by 64 multiplier giving the low 64 bits of the product.
module bsc_mul64 (
  input  logic                         clk,
  input  logic                         en,
  input  logic [bsc_pkg::WIDE_W-1:0]   a,
  input  logic [bsc_pkg::WIDE_W-1:0]   b,
  output logic [bsc_pkg::WIDE_W-1:0]   p
);

  localparam int HALF_W = bsc_pkg::WIDE_W / 2;

  logic [bsc_pkg::WIDE_W-1:0] ll;
  logic [HALF_W-1:0]          lh;
  logic [HALF_W-1:0]          hl;

  // The high by high partial product falls wholly above bit 63.
  always_ff @(posedge clk) begin
    if (en) begin
      ll <= bsc_pkg::WIDE_W'(a[HALF_W-1:0]) * bsc_pkg::WIDE_W'(b[HALF_W-1:0]);
      lh <= a[HALF_W-1:0] * b[bsc_pkg::WIDE_W-1:HALF_W];
      hl <= a[bsc_pkg::WIDE_W-1:HALF_W] * b[HALF_W-1:0];
      p  <= ll + {lh + hl, {HALF_W{1'b0}}};
    end
  end

endmodule

>>> rtl/bsc_div.sv
// Pipelined restoring divider of unsigned magnitudes, one quotient bit per stage.
module bsc_div #(
  parameter int QW = bsc_pkg::WIDE_W,
  parameter int DW = bsc_pkg::DEN_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [QW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem [QW-1];
  logic [DW-1:0] dv  [QW-1];
  logic [QW-1:0] dq  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] pr;
    logic [DW-1:0] pd;
    logic [QW-1:0] pq;
    logic [DW:0]   tr;
    logic          ge;

    if (k == 0) begin : g_first
      assign pr = '0;
      assign pq = num;
      assign pd = den;
    end else begin : g_next
      assign pr = rem[k-1];
      assign pq = dq[k-1];
      assign pd = dv[k-1];
    end

    // The remainder stays below the divisor, so it fits back into DW bits.
    assign tr = {pr, pq[QW-1]};
    assign ge = tr >= {1'b0, pd};

    always_ff @(posedge clk) begin
      if (en) begin
        dq[k] <= {pq[QW-2:0], ge};
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? DW'(tr - {1'b0, pd}) : tr[DW-1:0];
          dv[k]  <= pd;
        end
      end
    end
  end

  assign quo = dq[QW-1];

endmodule

>>> rtl/baro_sensor_compensation.sv
// Top level of the barometric compensation pipeline.
// One raw temperature and pressure pair is accepted every clock cycle while no held
// result stalls the pipeline, and it passes through ten stages of 32-bit temperature
// work and pressure terms, two stages for each 64-bit multiply, and a 64-stage divider
// that settles one quotient bit per stage and makes up most of the pipeline. When the
// result is not taken the whole pipeline holds, so input ready falls in the same cycle.
// Coefficient registers reset to zero, are written through the always-ready configuration
// channel, and ignore a write to an index beyond the register list.
module baro_sensor_compensation (
  input  logic                 clk,
  input  logic                 rst,
  bsc_sample_if.sink           sample,
  bsc_result_if.source         result,
  bsc_cfg_if.sink              cfg
);

  localparam int W        = bsc_pkg::WIDE_W;
  localparam int ST_TEMP  = 5;
  localparam int ST_ADP   = 8;
  localparam int ST_DIV0  = 12;
  localparam int ST_DIVQ  = ST_DIV0 + W;
  localparam int ST_Q     = ST_DIVQ + 1;
  localparam int ST_MA    = ST_Q + bsc_pkg::MUL_LAT;
  localparam int ST_MB    = ST_MA + bsc_pkg::MUL_LAT;
  localparam int ST_SUM   = ST_MB + 1;
  localparam int ST_OUT   = ST_SUM + 1;
  localparam int LAT      = ST_OUT + 1;

  // Coefficient registers.
  logic [15:0]        t1;
  logic signed [15:0] t2;
  logic signed [15:0] t3;
  logic [15:0]        p1;
  logic [W-1:0]       pc25;
  logic [W-1:0]       pc69;

  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  assign p2 = $signed(pc25[15:0]);
  assign p3 = $signed(pc25[31:16]);
  assign p4 = $signed(pc25[47:32]);
  assign p5 = $signed(pc25[63:48]);
  assign p6 = $signed(pc69[15:0]);
  assign p7 = $signed(pc69[31:16]);
  assign p8 = $signed(pc69[47:32]);
  assign p9 = $signed(pc69[63:48]);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1   <= '0;
      t2   <= '0;
      t3   <= '0;
      p1   <= '0;
      pc25 <= '0;
      pc69 <= '0;
    end else if (cfg.valid) begin
      unique case (bsc_pkg::cfg_reg_t'(cfg.index))
        bsc_pkg::REG_TEMP_ONE:   t1   <= cfg.data[15:0];
        bsc_pkg::REG_TEMP_TWO:   t2   <= $signed(cfg.data[15:0]);
        bsc_pkg::REG_TEMP_THREE: t3   <= $signed(cfg.data[15:0]);
        bsc_pkg::REG_PRESS_ONE:  p1   <= cfg.data[15:0];
        bsc_pkg::REG_PRESS_2_5:  pc25 <= cfg.data;
        bsc_pkg::REG_PRESS_6_9:  pc69 <= cfg.data;
        default: ;
      endcase
    end
  end

  // Pipeline control: every stage advances together unless the result is held.
  logic [LAT-1:0] vld;
  logic           adv;
  logic           acc;

  assign adv          = !vld[LAT-1] || result.ready;
  assign sample.ready = adv;
  assign acc          = sample.valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], acc};
    end
  end

  // Temperature stages.
  logic signed [18:0] s1_a;
  logic signed [17:0] s1_b;
  logic signed [34:0] s2_m1;
  logic signed [35:0] s2_bb;
  logic signed [20:0] s3_v1;
  logic signed [19:0] s3_bb2;
  logic signed [35:0] s4_m3;
  logic signed [20:0] s4_v1;
  logic signed [21:0] s5_fine;
  logic signed [25:0] temp_full;
  logic signed [23:0] s6_x;

  logic [bsc_pkg::RAW_W-1:0] adp_p [ST_ADP+1];
  logic signed [bsc_pkg::TEMP_W-1:0] tmp_p [ST_TEMP:ST_OUT];

  assign temp_full = 26'(s5_fine * 5 + bsc_pkg::TEMP_ROUND);

  // Pressure terms ahead of the divisor.
  logic signed [47:0] s7_xx;
  logic signed [39:0] s7_xp5;
  logic signed [39:0] s7_xp2;
  logic signed [W-1:0] s8_y0;
  logic signed [W-1:0] s8_xxp3;
  logic signed [39:0] s8_xp5;
  logic signed [39:0] s8_xp2;
  logic signed [W-1:0] s9_y;
  logic signed [W-1:0] s9_x2;
  logic signed [W-1:0] s10_d0;
  logic [W-1:0]        s10_num;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a    <= $signed({2'b00, sample.raw_temperature[19:3]}) - $signed({2'b00, t1, 1'b0});
      s1_b    <= $signed({2'b00, sample.raw_temperature[19:4]}) - $signed({2'b00, t1});
      s2_m1   <= 35'(s1_a) * 35'(t2);
      s2_bb   <= 36'(s1_b) * 36'(s1_b);
      s3_v1   <= $signed(s2_m1[31:11]);
      s3_bb2  <= $signed(s2_bb[31:12]);
      s4_m3   <= 36'(s3_bb2) * 36'(t3);
      s4_v1   <= s3_v1;
      s5_fine <= 22'(s4_v1) + 22'($signed(s4_m3[31:14]));
      tmp_p[ST_TEMP] <= 24'(temp_full >>> 8);
      s6_x    <= 24'(s5_fine) - 24'(bsc_pkg::FINE_OFFSET);
      s7_xx   <= 48'(s6_x) * 48'(s6_x);
      s7_xp5  <= 40'(s6_x) * 40'(p5);
      s7_xp2  <= 40'(s6_x) * 40'(p2);
      s8_y0   <= 64'(s7_xx) * 64'(p6);
      s8_xxp3 <= 64'(s7_xx) * 64'(p3);
      s8_xp5  <= s7_xp5;
      s8_xp2  <= s7_xp2;
      s9_y    <= s8_y0 + (64'(s8_xp5) <<< 17) + (64'(p4) <<< bsc_pkg::Y_P4_SHIFT);
      s9_x2   <= (s8_xxp3 >>> 8) + (64'(s8_xp2) <<< 12);
      s10_d0  <= (64'sd1 <<< bsc_pkg::DIV_BIAS_SHIFT) + s9_x2;
      s10_num <= ((64'(bsc_pkg::PRESS_BASE) - 64'(adp_p[ST_ADP])) << 31) - s9_y;
      adp_p[0] <= sample.raw_pressure;
      for (int k = 1; k <= ST_ADP; k++) begin
        adp_p[k] <= adp_p[k-1];
      end
      for (int k = ST_TEMP + 1; k <= ST_OUT; k++) begin
        tmp_p[k] <= tmp_p[k-1];
      end
    end
  end

  // Divisor and scaled numerator.
  logic [W-1:0] prod_div;
  logic [W-1:0] prod_num;

  bsc_mul64 u_mul_div (
    .clk (clk), .en (adv), .a (s10_d0), .b ({48'd0, p1}), .p (prod_div)
  );

  bsc_mul64 u_mul_num (
    .clk (clk), .en (adv), .a (s10_num), .b (64'(bsc_pkg::PRESS_SCALE)), .p (prod_num)
  );

  logic signed [bsc_pkg::DEN_W-1:0] divisor;
  logic [bsc_pkg::DEN_W-1:0]        den_mag;
  logic [W-1:0]                     num_mag;
  logic                             dz_p  [ST_DIV0:ST_OUT];
  logic                             neg_p [ST_DIV0:ST_DIVQ];
  logic [W-1:0]                     quo;

  assign divisor = $signed(prod_div[W-1:bsc_pkg::DIV_SHIFT]);

  always_ff @(posedge clk) begin
    if (adv) begin
      den_mag        <= divisor[bsc_pkg::DEN_W-1] ? (31'd0 - divisor) : divisor;
      num_mag        <= prod_num[W-1] ? (64'd0 - prod_num) : prod_num;
      dz_p[ST_DIV0]  <= divisor == '0;
      neg_p[ST_DIV0] <= prod_num[W-1] ^ divisor[bsc_pkg::DEN_W-1];
      for (int k = ST_DIV0 + 1; k <= ST_OUT; k++) begin
        dz_p[k] <= dz_p[k-1];
      end
      for (int k = ST_DIV0 + 1; k <= ST_DIVQ; k++) begin
        neg_p[k] <= neg_p[k-1];
      end
    end
  end

  bsc_div #(.QW (W), .DW (bsc_pkg::DEN_W)) u_div (
    .clk (clk), .en (adv), .num (num_mag), .den (den_mag), .quo (quo)
  );

  // Final pressure correction.
  logic [W-1:0]        q_next;
  logic signed [W-1:0] qs_next;
  logic [W-1:0]        q_p [ST_Q:ST_MB];
  logic [W-1:0]        s_p [ST_Q:ST_MA];
  logic [W-1:0]        prod_t;
  logic [W-1:0]        prod_u;
  logic [W-1:0]        prod_w;
  logic signed [W-1:0] u_sh;
  logic signed [W-1:0] w_sh;
  logic signed [W-1:0] s_sum;
  logic signed [W-1:0] fin;
  logic [bsc_pkg::PRESS_W-1:0] press;

  assign q_next  = neg_p[ST_DIVQ] ? (64'd0 - quo) : quo;
  assign qs_next = $signed(q_next) >>> 13;
  assign u_sh    = $signed(prod_u) >>> 25;
  assign w_sh    = $signed(prod_w) >>> 19;
  assign fin     = (s_sum >>> 8) + (64'(p7) <<< 4);

  always_ff @(posedge clk) begin
    if (adv) begin
      q_p[ST_Q] <= q_next;
      s_p[ST_Q] <= qs_next;
      for (int k = ST_Q + 1; k <= ST_MB; k++) begin
        q_p[k] <= q_p[k-1];
      end
      for (int k = ST_Q + 1; k <= ST_MA; k++) begin
        s_p[k] <= s_p[k-1];
      end
      s_sum <= $signed(q_p[ST_MB]) + u_sh + w_sh;
      if (dz_p[ST_SUM] || fin[W-1]) begin
        press <= '0;
      end else if (fin[W-1:bsc_pkg::PRESS_W] != '0) begin
        press <= '1;
      end else begin
        press <= fin[bsc_pkg::PRESS_W-1:0];
      end
    end
  end

  bsc_mul64 u_mul_t (
    .clk (clk), .en (adv), .a (64'(p9)), .b (s_p[ST_Q]), .p (prod_t)
  );

  bsc_mul64 u_mul_u (
    .clk (clk), .en (adv), .a (prod_t), .b (s_p[ST_MA]), .p (prod_u)
  );

  bsc_mul64 u_mul_w (
    .clk (clk), .en (adv), .a (64'(p8)), .b (q_p[ST_MA]), .p (prod_w)
  );

  assign result.valid             = vld[LAT-1];
  assign result.temperature_centi = tmp_p[ST_OUT];
  assign result.pressure_q24_8    = press;
  assign result.divisor_zero      = dz_p[ST_OUT];

  // A transfer in always shows up in the first stage on the next edge.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> vld[0])
    else $error("accepted sample did not enter the pipeline");

  // A held result must stall the input side in the same cycle.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !sample.ready)
    else $error("input accepted while a result was held");

  // A zero divisor forces the reported pressure to zero.
  a_zero_divisor: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.divisor_zero |-> result.pressure_q24_8 == '0)
    else $error("pressure not zero on zero divisor");

endmodule

>>> tb/bsc_checker.sv
// Checker that predicts compensated results from observed transfers and compares them.
`timescale 1ns / 100ps
module bsc_checker (
  input  logic             clk,
  input  logic             rst,
  bsc_sample_if.sink       sample,
  bsc_result_if.sink       result,
  bsc_cfg_if.sink          cfg,
  output int               failures,
  output int               pending
);
  import bsc_pkg::*;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [PRESS_W-1:0]       pressure;
    logic                     dz;
  } comp_result_t;

  logic [15:0] t1_word, t2_word, t3_word, p1_word;
  logic [63:0] p25_word, p69_word;
  comp_result_t awaited_results[$];
  int          results_seen;
  int          dz_seen;

  function automatic longint asr64(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint asr32(longint x, int n);
    int v;
    v = int'(x);
    return longint'(v >>> n);
  endfunction

  function automatic longint pw(logic [63:0] r, int k);
    logic signed [15:0] w;
    w = r[16*k +: 16];
    return longint'(w);
  endfunction

  function automatic comp_result_t compensate(logic [RAW_W-1:0] adt_u, logic [RAW_W-1:0] adp_u);
    comp_result_t r;
    longint adt, adp, t1, t2, t3, p1, a, b, v1, v2, fine, tmp, x, y, dv, p, num;
    adt = longint'({44'd0, adt_u});
    adp = longint'({44'd0, adp_u});
    t1 = longint'({48'd0, t1_word});
    t2 = longint'($signed(t2_word));
    t3 = longint'($signed(t3_word));
    p1 = longint'({48'd0, p1_word});
    a = (adt >>> 3) - (t1 <<< 1);
    v1 = asr32(a * t2, 11);
    b = (adt >>> 4) - t1;
    v2 = asr32(asr32(b * b, 12) * t3, 14);
    fine = longint'(int'(v1 + v2));
    tmp = asr32(longint'(int'(fine * 5)) + TEMP_ROUND, 8);
    if (tmp > 8388607) tmp = 8388607;
    if (tmp < -8388608) tmp = -8388608;
    r.temperature = tmp[TEMP_W-1:0];
    x = fine - FINE_OFFSET;
    y = x * x * pw(p69_word, 0);
    y = y + ((x * pw(p25_word, 3)) <<< 17);
    y = y + (pw(p25_word, 2) <<< Y_P4_SHIFT);
    x = asr64(x * x * pw(p25_word, 1), 8) + ((x * pw(p25_word, 0)) <<< 12);
    dv = asr64(((64'sd1 <<< DIV_BIAS_SHIFT) + x) * p1, DIV_SHIFT);
    if (dv == 0) begin
      r.dz = 1'b1;
      r.pressure = '0;
    end else begin
      r.dz = 1'b0;
      p = PRESS_BASE - adp;
      num = ((p <<< 31) - y) * PRESS_SCALE;
      if (dv == -1) p = -num;
      else p = num / dv;
      x = asr64(pw(p69_word, 3) * asr64(p, 13) * asr64(p, 13), 25);
      y = asr64(pw(p69_word, 2) * p, 19);
      p = asr64(p + x + y, 8) + (pw(p69_word, 1) <<< 4);
      if (p < 0) r.pressure = '0;
      else if (p > 64'sh0_FFFF_FFFF) r.pressure = '1;
      else r.pressure = p[31:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    comp_result_t e;
    if (rst) begin
      t1_word <= '0; t2_word <= '0; t3_word <= '0; p1_word <= '0;
      p25_word <= '0; p69_word <= '0;
      failures = 0;
      pending = 0;
      results_seen = 0;
      dz_seen = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_TEMP_ONE:   t1_word <= cfg.data[15:0];
          REG_TEMP_TWO:   t2_word <= cfg.data[15:0];
          REG_TEMP_THREE: t3_word <= cfg.data[15:0];
          REG_PRESS_ONE:  p1_word <= cfg.data[15:0];
          REG_PRESS_2_5:  p25_word <= cfg.data;
          REG_PRESS_6_9:  p69_word <= cfg.data;
          default: ;
        endcase
      end
      if (sample.valid && sample.ready)
        awaited_results.push_back(compensate(sample.raw_temperature, sample.raw_pressure));
      if (result.valid && result.ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          failures++;
          $display("%0t: unexpected result transfer t=%0d p=%0d dz=%0b", $time,
                   result.temperature_centi, result.pressure_q24_8, result.divisor_zero);
        end else begin
          e = awaited_results.pop_front();
          if (e.dz) dz_seen++;
          if (e.temperature !== result.temperature_centi) begin
            failures++;
            $display("%0t: temperature expected %0d actual %0d", $time,
                     e.temperature, result.temperature_centi);
          end
          if (e.pressure !== result.pressure_q24_8) begin
            failures++;
            $display("%0t: pressure expected %0d actual %0d", $time,
                     e.pressure, result.pressure_q24_8);
          end
          if (e.dz !== result.divisor_zero) begin
            failures++;
            $display("%0t: divisor_zero expected %0b actual %0b", $time,
                     e.dz, result.divisor_zero);
          end
        end
      end
      pending = awaited_results.size();
    end
  end
endmodule

>>> tb/baro_sensor_compensation_test.sv
// Testbench top: stimulus for the barometric compensation block and the verdict.
`timescale 1ns / 100ps
module baro_sensor_compensation_test;
  import bsc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   failures, pending;
  int   sent = 0;
  int   burst_left = 0;
  bit   stall_mode = 0;

  bsc_sample_if sample ();
  bsc_result_if result ();
  bsc_cfg_if    cfg ();

  baro_sensor_compensation i_dut (.clk(clk), .rst(rst), .sample(sample.sink),
                                  .result(result.source), .cfg(cfg.sink));
  bsc_checker i_checker (.clk(clk), .rst(rst), .sample(sample.sink), .result(result.sink),
                         .cfg(cfg.sink), .failures(failures), .pending(pending));

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    sample.valid = 1'b0; sample.raw_temperature = '0; sample.raw_pressure = '0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    result.ready = 1'b0;
  end

  // Receiver stalls in its own pattern; some phases never stall.
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    if (stall_mode) result.ready <= ($urandom_range(0, 3) != 0);
    else result.ready <= 1'b1;
  end

  // Valid stays high after the transfer so that writes can follow back to back.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  // Waits until every awaited result has come, then lets the pipeline drain.
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Valid stays high after the transfer; the caller drops it when a gap follows.
  task automatic send_pair(logic [RAW_W-1:0] rt, logic [RAW_W-1:0] rp, bit bursty);
    if (bursty) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 2) == 0) begin
          sample.valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
    end
    sample.valid <= 1'b1;
    sample.raw_temperature <= rt;
    sample.raw_pressure <= rp;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Typical datasheet-like calibration with some random spread.
  task automatic typical_cal();
    write_reg(REG_TEMP_ONE, 64'(27504 + $urandom_range(0, 2000) - 1000));
    write_reg(REG_TEMP_TWO, 64'(26435 + $urandom_range(0, 2000) - 1000));
    write_reg(REG_TEMP_THREE, 64'(16'(-1000 + $urandom_range(0, 200))));
    write_reg(REG_PRESS_ONE, 64'(36477 + $urandom_range(0, 2000) - 1000));
    write_reg(REG_PRESS_2_5, {16'd140, 16'd2855, 16'd3024, 16'(-10685)});
    write_reg(REG_PRESS_6_9, {16'd6000, 16'(-14600), 16'd15500, 16'(-7)});
    cfg.valid <= 1'b0;
  endtask

  task automatic random_cal();
    write_reg(REG_TEMP_ONE, rand64());
    write_reg(REG_TEMP_TWO, rand64());
    write_reg(REG_TEMP_THREE, rand64());
    write_reg(REG_PRESS_ONE, rand64());
    write_reg(REG_PRESS_2_5, rand64());
    write_reg(REG_PRESS_6_9, rand64());
    cfg.valid <= 1'b0;
  endtask

  task automatic random_run(int count, bit typical_raw);
    logic [RAW_W-1:0] rt, rp;
    for (int i = 0; i < count; i++) begin
      if (typical_raw && $urandom_range(0, 4) != 0) begin
        rt = RAW_W'($urandom_range(400000, 600000));
        rp = RAW_W'($urandom_range(250000, 500000));
      end else begin
        rt = RAW_W'($urandom);
        rp = RAW_W'($urandom);
      end
      send_pair(rt, rp, 1'b1);
    end
    burst_left = 0;
    sample.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // All-zero calibration: divisor zero on every item.
    send_pair('0, '0, 1'b0);
    send_pair('1, '1, 1'b0);
    sample.valid <= 1'b0;
    drain();
    typical_cal();
    send_pair('0, '0, 1'b0);
    send_pair('1, '1, 1'b0);
    send_pair('1, '0, 1'b0);
    send_pair('0, '1, 1'b0);
    send_pair(20'd519888, 20'd415148, 1'b0);
    send_pair(20'hAAAAA, 20'h55555, 1'b0);
    sample.valid <= 1'b0;
    drain();
    // Extreme calibration words, then unknown register indexes that must be ignored.
    write_reg(REG_TEMP_ONE, 64'hFFFF);
    write_reg(REG_TEMP_TWO, 64'h8000);
    write_reg(REG_TEMP_THREE, 64'h7FFF);
    write_reg(REG_PRESS_ONE, 64'hFFFF);
    write_reg(REG_PRESS_2_5, 64'h8000_7FFF_8000_7FFF);
    write_reg(REG_PRESS_6_9, 64'h7FFF_8000_7FFF_8000);
    write_reg(3'd6, '0);
    write_reg(3'd7, '0);
    cfg.valid <= 1'b0;
    send_pair('0, '0, 1'b0);
    send_pair('1, '1, 1'b0);
    send_pair(20'h55555, 20'hAAAAA, 1'b0);
    sample.valid <= 1'b0;
    drain();
    write_reg(REG_TEMP_TWO, 64'h7FFF);
    write_reg(REG_TEMP_THREE, 64'h8000);
    write_reg(REG_PRESS_2_5, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg.valid <= 1'b0;
    send_pair('0, '1, 1'b0);
    send_pair('1, '0, 1'b0);
    sample.valid <= 1'b0;
    drain();

    for (int phase = 0; phase < 14; phase++) begin
      if (phase % 3 == 2) random_cal();
      else typical_cal();
      random_run(100, phase % 3 != 2);
      drain();
    end

    repeat (100) @(posedge clk);
    $display("Sent %0d sample pairs over 18 calibration settings, %0d results with a zero divisor.",
             sent, i_checker.dz_seen);
    if (failures == 0 && pending == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #4ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule

>>> files.f
rtl/bsc_pkg.sv
rtl/bsc_channels.sv
rtl/bsc_mul64.sv
rtl/bsc_div.sv
rtl/baro_sensor_compensation.sv
tb/bsc_checker.sv
tb/baro_sensor_compensation_test.sv
